// ===== hw/rtl/fat12_chain_table_macros.svh =====
// ----------------------------------------------------------------------------
// fat12_chain_table_macros.svh - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef FAT12_CHAIN_TABLE_MACROS_SVH
`define FAT12_CHAIN_TABLE_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define FCT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define FCT_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/fct_pkg.sv =====
// ----------------------------------------------------------------------------
// fct_pkg - FAT12 chain table package
// Types, codes and helpers shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package fct_pkg;

  localparam int TABLE_BYTES_DEF = 4608;

  localparam logic [11:0] CHAIN_END = 12'hFFF;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_READ   = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_FREE   = 2'd3
  } mode_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_CHAIN = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_RDATA,
    S_RLO,
    S_RHI,
    S_DEC,
    S_CLR0,
    S_CLR1,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture_in;
    logic set_range;
    logic set_chain;
    logic wr_byte;
    logic rd_byte;
    logic cap_rbyte;
    logic rd_lo;
    logic rd_hi;
    logic cap_lo;
    logic cap_hi;
    logic cap_next;
    logic clr_lo;
    logic clr_hi;
    logic step;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    mode_t mode;
    logic  addr_ok;
    logic  clus_ok;
    logic  start_ok;
    logic  link_zero;
    logic  link_end;
    logic  link_ok;
  } sts_t;

  // Byte offset of a 12-bit entry: c + c/2.
  function automatic logic [12:0] entry_off(input logic [11:0] c);
    entry_off = {1'b0, c} + {2'b00, c[11:1]};
  endfunction

endpackage

// ===== hw/rtl/fct_ram.sv =====
// ----------------------------------------------------------------------------
// fct_ram - generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4608,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/fct_ctrl.sv =====
// ----------------------------------------------------------------------------
// fct_ctrl - FAT12 chain table controller
// Sequences each request through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
`include "fat12_chain_table_macros.svh"

module fct_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  fct_pkg::sts_t sts,
  output fct_pkg::cmd_t cmd
);
  import fct_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_START;
      S_START: begin
        case (sts.mode)
          MODE_LOAD:   state_next = S_DONE;
          MODE_READ:   state_next = sts.addr_ok ? S_RDATA : S_DONE;
          MODE_LOOKUP: state_next = sts.clus_ok ? S_RLO : S_DONE;
          MODE_FREE:   state_next = (sts.clus_ok && sts.start_ok) ? S_RLO : S_DONE;
          default:     state_next = S_DONE;
        endcase
      end
      S_RDATA: state_next = S_DONE;
      S_RLO:   state_next = S_RHI;
      S_RHI:   state_next = S_DEC;
      S_DEC: begin
        if (sts.mode == MODE_LOOKUP || sts.link_zero) state_next = S_DONE;
        else state_next = S_CLR0;
      end
      S_CLR0:  state_next = S_CLR1;
      S_CLR1: begin
        if (sts.link_end || !sts.link_ok) state_next = S_DONE;
        else state_next = S_RLO;
      end
      S_DONE:  if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    in_ready       = (state == S_IDLE);
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE:  cmd.capture_in = in_valid;
      S_START: begin
        case (sts.mode)
          MODE_LOAD: begin
            cmd.set_range = !sts.addr_ok;
            cmd.wr_byte   = sts.addr_ok;
          end
          MODE_READ: begin
            cmd.set_range = !sts.addr_ok;
            cmd.rd_byte   = sts.addr_ok;
          end
          MODE_LOOKUP: cmd.set_range = !sts.clus_ok;
          MODE_FREE:   cmd.set_range = !(sts.clus_ok && sts.start_ok);
          default:     cmd.set_range = 1'b1;
        endcase
      end
      S_RDATA: cmd.cap_rbyte = 1'b1;
      S_RLO:   cmd.rd_lo = 1'b1;
      S_RHI: begin
        cmd.rd_hi  = 1'b1;
        cmd.cap_lo = 1'b1;
      end
      S_DEC: begin
        cmd.cap_hi    = 1'b1;
        cmd.cap_next  = (sts.mode == MODE_LOOKUP);
        cmd.set_chain = (sts.mode != MODE_LOOKUP) && sts.link_zero;
      end
      S_CLR0:  cmd.clr_lo = 1'b1;
      S_CLR1: begin
        cmd.clr_hi    = 1'b1;
        cmd.set_chain = !sts.link_end && !sts.link_ok;
        cmd.step      = !sts.link_end && sts.link_ok;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  `FCT_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state == S_START, "accept did not start")
  `FCT_ASSERT_NEXT(a_done_loads, state == S_DONE && slot_free, out_valid && state == S_IDLE, "result not loaded")
  `FCT_ASSERT_NEXT(a_clear_pair, state == S_CLR0, state == S_CLR1 && $past(cmd.clr_lo), "clear pair broken")
  `FCT_ASSERT_SAME(a_no_overwrite, cmd.load_out, !out_valid || out_ready, "pending result overwritten")

endmodule

// ===== hw/rtl/fct_dp.sv =====
// ----------------------------------------------------------------------------
// fct_dp - FAT12 chain table datapath
// Table store, entry decode and clear, range checks and result registers.
// ----------------------------------------------------------------------------
module fct_dp #(
  parameter int TABLE_BYTES = fct_pkg::TABLE_BYTES_DEF
) (
  input  logic          clk,
  input  logic [1:0]    mode,
  input  logic [12:0]   byte_addr,
  input  logic [7:0]    byte_data,
  input  logic [11:0]   cluster,
  output logic [7:0]    read_byte,
  output logic [11:0]   next_cluster,
  output logic [11:0]   freed_count,
  output logic [1:0]    status,
  input  fct_pkg::cmd_t cmd,
  output fct_pkg::sts_t sts
);
  import fct_pkg::*;

  localparam int          AW = (TABLE_BYTES > 1) ? $clog2(TABLE_BYTES) : 1;
  localparam logic [13:0] TB = 14'(TABLE_BYTES);

  mode_t       mode_q;
  logic [12:0] addr_q;
  logic [7:0]  data_q;
  logic [11:0] cur;
  logic [7:0]  lo_q;
  logic [7:0]  hi_q;
  logic [11:0] link_q;
  logic [7:0]  rbyte_q;
  logic [11:0] next_q;
  logic [11:0] count_q;
  logic [1:0]  status_q;

  logic [12:0]   off;
  logic [12:0]   off_hi;
  logic [15:0]   pair;
  logic [11:0]   link_c;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  function automatic logic in_store(input logic [11:0] c);
    in_store = ({1'b0, entry_off(c)} + 14'd1) < TB;
  endfunction

  assign off    = entry_off(cur);
  assign off_hi = off + 13'd1;
  assign pair   = {ram_rdata, lo_q};
  assign link_c = cur[0] ? pair[15:4] : pair[11:0];

  assign sts.mode      = mode_q;
  assign sts.addr_ok   = {1'b0, addr_q} < TB;
  assign sts.clus_ok   = in_store(cur);
  assign sts.start_ok  = (cur >= 12'd2);
  assign sts.link_zero = (link_c == 12'd0);
  assign sts.link_end  = (link_q == CHAIN_END);
  assign sts.link_ok   = (link_q >= 12'd2) && in_store(link_q);

  // Write port: a loaded byte, or one half of a cleared entry.
  always_comb begin
    ram_we    = cmd.wr_byte || cmd.clr_lo || cmd.clr_hi;
    ram_waddr = addr_q[AW-1:0];
    ram_wdata = data_q;
    if (cmd.clr_lo) begin
      ram_waddr = off[AW-1:0];
      ram_wdata = cur[0] ? (lo_q & 8'h0F) : 8'h00;
    end else if (cmd.clr_hi) begin
      ram_waddr = off_hi[AW-1:0];
      ram_wdata = cur[0] ? 8'h00 : (hi_q & 8'hF0);
    end
  end

  // Read port: the entry's first byte unless another byte is asked for.
  always_comb begin
    ram_raddr = off[AW-1:0];
    if (cmd.rd_byte) ram_raddr = addr_q[AW-1:0];
    else if (cmd.rd_hi) ram_raddr = off_hi[AW-1:0];
    else if (cmd.rd_lo) ram_raddr = off[AW-1:0];
  end

  fct_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture_in) begin
      mode_q   <= mode_t'(mode);
      addr_q   <= byte_addr;
      data_q   <= byte_data;
      cur      <= cluster;
      rbyte_q  <= 8'd0;
      next_q   <= 12'd0;
      count_q  <= 12'd0;
      status_q <= STATUS_OK;
    end
    if (cmd.set_range) status_q <= STATUS_RANGE;
    if (cmd.set_chain) status_q <= STATUS_CHAIN;
    if (cmd.cap_rbyte) rbyte_q <= ram_rdata;
    if (cmd.cap_lo) lo_q <= ram_rdata;
    if (cmd.cap_hi) begin
      hi_q   <= ram_rdata;
      link_q <= link_c;
    end
    if (cmd.cap_next) next_q <= link_c;
    if (cmd.clr_lo) count_q <= count_q + 12'd1;
    if (cmd.step) cur <= link_q;
    if (cmd.load_out) begin
      read_byte    <= rbyte_q;
      next_cluster <= next_q;
      freed_count  <= count_q;
      status       <= status_q;
    end
  end

endmodule

// ===== hw/rtl/fat12_chain_table.sv =====
// ----------------------------------------------------------------------------
// fat12_chain_table - FAT12 cluster chain table
// Byte store of packed 12-bit FAT entries with load, read, lookup and free.
// ----------------------------------------------------------------------------
// The table lives in one byte-wide RAM of TABLE_BYTES bytes with a
// registered read port, and every request is handled one at a time by a
// controller that steps a datapath through that RAM. A load or any request
// rejected for range goes from the start state straight to the done state,
// a byte read first captures the byte it asked for, and a next-cluster
// lookup reads the entry's two bytes and decodes the link. Freeing a chain
// walks it entry by entry, and a walk that reaches an entry that is already
// free stops after reading and decoding it: each cleared entry costs two RAM
// reads for its two bytes, a decode of the link and two RAM writes to clear
// it, and the next entry is only read after the current one is written back
// because neighboring entries share a byte. A new request is accepted while
// the previous result still waits at the output register. Bytes that were
// never loaded read back undefined, so the table must be loaded before use.
// A free stops with status 2 at an entry that is already free, at a link of
// 1, or at a link outside the store; entries cleared up to that point stay
// cleared and are counted in freed_count.
// ----------------------------------------------------------------------------
module fat12_chain_table #(
  parameter int TABLE_BYTES = fct_pkg::TABLE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [12:0] byte_addr,
  input  logic [7:0]  byte_data,
  input  logic [11:0] cluster,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_byte,
  output logic [11:0] next_cluster,
  output logic [11:0] freed_count,
  output logic [1:0]  status
);
  import fct_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller owns both handshakes and the sequencing of each request.
  fct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the store, the request and the result registers.
  fct_dp #(
    .TABLE_BYTES (TABLE_BYTES)
  ) u_dp (
    .clk          (clk),
    .mode         (mode),
    .byte_addr    (byte_addr),
    .byte_data    (byte_data),
    .cluster      (cluster),
    .read_byte    (read_byte),
    .next_cluster (next_cluster),
    .freed_count  (freed_count),
    .status       (status),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

// ===== tb/sv/fat12_chain_table_tb.sv =====
// ----------------------------------------------------------------------------
// fat12_chain_table_tb - self-checking bench for the FAT12 chain table
// Builds cluster chains in the packed table, looks them up and frees them,
// mixes in random requests, and checks each result against a predictor.
// ----------------------------------------------------------------------------
// A short table of directed requests covers the extremes of the fields and
// every error status. Random traffic follows: most of it writes whole chains
// entry by entry, looks up members and frees them from a start cluster, with
// bad tails, loops and out-of-store links mixed in. The rest is random noise,
// half of it over the full range of each field. The bench mirrors the byte
// store and remembers which bytes were loaded. Any request that would read a
// byte that was never loaded is preceded by loads of the missing bytes, so
// the block never returns undefined data.
// ----------------------------------------------------------------------------
module fat12_chain_table_tb;
  import fct_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int STORE_BYTES    = TABLE_BYTES_DEF;
  localparam int RANDOM_ITEMS   = 515;
  localparam int IDLE_PCT       = 18;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 60;
  localparam int TIMEOUT_CYCLES = 500000;
  localparam int MAX_REPORTS    = 10;
  localparam int PROBE_ROWS     = 25;

  typedef struct packed {
    mode_t       mode;
    logic [12:0] addr;
    logic [7:0]  data;
    logic [11:0] clus;
  } fat_req_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [11:0] next_cluster;
    logic [11:0] freed_count;
    logic [1:0]  status;
  } fat_rsp_t;

  // A directed request; when typed is set, rsp is the result it must give.
  typedef struct packed {
    fat_req_t req;
    logic     typed;
    fat_rsp_t rsp;
  } probe_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [1:0]  mode      = MODE_LOAD;
  logic [12:0] byte_addr = '0;
  logic [7:0]  byte_data = '0;
  logic [11:0] cluster   = '0;
  logic        out_ready = 1'b0;
  wire         in_ready;
  wire         out_valid;
  wire  [7:0]  read_byte;
  wire  [11:0] next_cluster;
  wire  [11:0] freed_count;
  wire  [1:0]  status;

  // Mirror of the byte store, and which of its bytes hold loaded data.
  bit [7:0]    fat_bytes [STORE_BYTES];
  bit          fat_known [STORE_BYTES];

  fat_rsp_t    results_due [$];
  fat_rsp_t    got_rsp;
  fat_rsp_t    want_rsp;
  int          items_sent = 0;
  int          errors     = 0;
  bit          calm       = 1'b0;
  int          hold_asked = 0;
  int          hold_done  = 0;

  // Directed requests. The chain 2 -> 3 -> 4 -> end sits in bytes 3 to 7;
  // entry 4 keeps the high nibble of byte 7, which becomes part of entry 5.
  // Cluster 3071 is the last one whose two bytes lie in the store.
  probe_row_t probe_rows [PROBE_ROWS] = '{
    '{'{MODE_LOAD,   13'd3,    8'h03, 12'd0},    1'b1, '{8'h00, 12'h000, 12'd0, STATUS_OK}},
    '{'{MODE_LOAD,   13'd4,    8'h40, 12'd0},    1'b1, '{8'h00, 12'h000, 12'd0, STATUS_OK}},
    '{'{MODE_LOAD,   13'd5,    8'h00, 12'd0},    1'b1, '{8'h00, 12'h000, 12'd0, STATUS_OK}},
    '{'{MODE_LOAD,   13'd6,    8'hFF, 12'd0},    1'b1, '{8'h00, 12'h000, 12'd0, STATUS_OK}},
    '{'{MODE_LOAD,   13'd7,    8'hAF, 12'd0},    1'b1, '{8'h00, 12'h000, 12'd0, STATUS_OK}},
    '{'{MODE_READ,   13'd4,    8'h00, 12'd0},    1'b1, '{8'h40, 12'h000, 12'd0, STATUS_OK}},
    '{'{MODE_LOOKUP, 13'd0,    8'h00, 12'd2},    1'b1, '{8'h00, 12'h003, 12'd0, STATUS_OK}},
    '{'{MODE_LOOKUP, 13'd0,    8'h00, 12'd3},    1'b1, '{8'h00, 12'h004, 12'd0, STATUS_OK}},
    '{'{MODE_LOOKUP, 13'd0,    8'h00, 12'd4},    1'b1, '{8'h00, 12'hFFF, 12'd0, STATUS_OK}},
    '{'{MODE_FREE,   13'd0,    8'h00, 12'd2},    1'b1, '{8'h00, 12'h000, 12'd3, STATUS_OK}},
    '{'{MODE_READ,   13'd7,    8'h00, 12'd0},    1'b1, '{8'hA0, 12'h000, 12'd0, STATUS_OK}},
    '{'{MODE_LOOKUP, 13'd0,    8'h00, 12'd3},    1'b1, '{8'h00, 12'h000, 12'd0, STATUS_OK}},
    '{'{MODE_FREE,   13'd0,    8'h00, 12'd2},    1'b1,
      '{8'h00, 12'h000, 12'd0, STATUS_CHAIN}},
    '{'{MODE_FREE,   13'd0,    8'h00, 12'd0},    1'b1,
      '{8'h00, 12'h000, 12'd0, STATUS_RANGE}},
    '{'{MODE_FREE,   13'd0,    8'h00, 12'd1},    1'b1,
      '{8'h00, 12'h000, 12'd0, STATUS_RANGE}},
    '{'{MODE_LOOKUP, 13'd0,    8'h00, 12'd4095}, 1'b1,
      '{8'h00, 12'h000, 12'd0, STATUS_RANGE}},
    '{'{MODE_LOOKUP, 13'd0,    8'h00, 12'd3072}, 1'b1,
      '{8'h00, 12'h000, 12'd0, STATUS_RANGE}},
    '{'{MODE_FREE,   13'd0,    8'h00, 12'd4095}, 1'b1,
      '{8'h00, 12'h000, 12'd0, STATUS_RANGE}},
    '{'{MODE_LOAD,   13'd8191, 8'h5A, 12'd0},    1'b1,
      '{8'h00, 12'h000, 12'd0, STATUS_RANGE}},
    '{'{MODE_READ,   13'd4608, 8'h00, 12'd0},    1'b1,
      '{8'h00, 12'h000, 12'd0, STATUS_RANGE}},
    '{'{MODE_LOAD,   13'd4606, 8'h1F, 12'd0},    1'b1, '{8'h00, 12'h000, 12'd0, STATUS_OK}},
    '{'{MODE_LOAD,   13'd4607, 8'h00, 12'd0},    1'b1, '{8'h00, 12'h000, 12'd0, STATUS_OK}},
    // Cluster 3071 links to 1, a reserved cluster: one entry is freed.
    '{'{MODE_FREE,   13'd0,    8'h00, 12'd3071}, 1'b0, '0},
    '{'{MODE_LOAD,   13'd8,    8'hC0, 12'd0},    1'b1, '{8'h00, 12'h000, 12'd0, STATUS_OK}},
    // Cluster 5 now links past the end of the store.
    '{'{MODE_FREE,   13'd0,    8'h00, 12'd5},    1'b0, '0}
  };

  fat12_chain_table dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .byte_addr    (byte_addr),
    .byte_data    (byte_data),
    .cluster      (cluster),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_byte    (read_byte),
    .next_cluster (next_cluster),
    .freed_count  (freed_count),
    .status       (status)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // True when both bytes of entry c lie inside the store.
  function automatic bit in_store(input int c);
    return c + (c >> 1) + 1 < STORE_BYTES;
  endfunction

  // Decode the 12-bit link of entry c from the mirror. An even entry is its
  // first byte plus the low nibble of the next; an odd entry is the high
  // nibble of its first byte plus the whole next byte.
  function automatic logic [11:0] entry_link(input int c);
    int off;
    off = c + (c >> 1);
    if (c % 2 == 1) return {fat_bytes[off + 1], fat_bytes[off][7:4]};
    return {fat_bytes[off + 1][3:0], fat_bytes[off]};
  endfunction

  // Zero the 12 bits of entry c, leaving the nibble its neighbor owns.
  function automatic void wipe_entry(input int c);
    int off;
    off = c + (c >> 1);
    if (c % 2 == 1) begin
      fat_bytes[off]     = fat_bytes[off] & 8'h0F;
      fat_bytes[off + 1] = 8'h00;
    end else begin
      fat_bytes[off]     = 8'h00;
      fat_bytes[off + 1] = fat_bytes[off + 1] & 8'hF0;
    end
  endfunction

  // First byte of entry c that was never loaded, or -1.
  function automatic int unloaded_byte(input int c);
    int off;
    off = c + (c >> 1);
    if (!fat_known[off]) return off;
    if (!fat_known[off + 1]) return off + 1;
    return -1;
  endfunction

  // Work out the result of one request. With commit set the mirror takes the
  // request's effect; without it this is a dry run. unk returns the first
  // unloaded byte the block would read, or -1. The free walk reads each link
  // before it clears the entry, and keeps its clears in an overlay so that a
  // loop in the chain ends on a cleared entry even in a dry run.
  function automatic void predict_table_op(input fat_req_t rq, input bit commit,
                                           output fat_rsp_t rsp, output int unk);
    bit          swept [int];
    int          cur;
    logic [11:0] link;
    bit          walking;
    rsp = '0;
    unk = -1;
    case (rq.mode)
      MODE_LOAD, MODE_READ: begin
        if (rq.addr >= STORE_BYTES) begin
          rsp.status = STATUS_RANGE;
        end else if (rq.mode == MODE_LOAD) begin
          if (commit) begin
            fat_bytes[rq.addr] = rq.data;
            fat_known[rq.addr] = 1'b1;
          end
        end else begin
          if (!fat_known[rq.addr]) unk = rq.addr;
          rsp.read_byte = fat_bytes[rq.addr];
        end
      end
      MODE_LOOKUP: begin
        if (!in_store(rq.clus)) begin
          rsp.status = STATUS_RANGE;
        end else begin
          unk = unloaded_byte(rq.clus);
          rsp.next_cluster = entry_link(rq.clus);
        end
      end
      default: begin
        if (rq.clus < 2 || !in_store(rq.clus)) begin
          rsp.status = STATUS_RANGE;
        end else begin
          cur = rq.clus;
          walking = 1'b1;
          while (walking) begin
            if (unk < 0) unk = unloaded_byte(cur);
            link = swept.exists(cur) ? 12'h000 : entry_link(cur);
            if (link == 12'h000) begin
              // Already free: stop without counting it.
              rsp.status = STATUS_CHAIN;
              walking = 1'b0;
            end else begin
              swept[cur] = 1'b1;
              rsp.freed_count = rsp.freed_count + 12'd1;
              if (link == CHAIN_END) begin
                walking = 1'b0;
              end else if (link < 2 || !in_store(link)) begin
                rsp.status = STATUS_CHAIN;
                walking = 1'b0;
              end else begin
                cur = link;
              end
            end
          end
          if (commit) foreach (swept[k]) wipe_entry(k);
        end
      end
    endcase
  endfunction

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  // Offer one request and hold it until the block takes it. The sender may
  // idle first, at random; the expected result is queued on acceptance.
  task automatic offer(input fat_req_t rq, input bit use_typed, input fat_rsp_t typed);
    fat_rsp_t due;
    int       unk;
    predict_table_op(rq, 1'b1, due, unk);
    if (use_typed) due = typed;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= rq.mode;
    byte_addr <= rq.addr;
    byte_data <= rq.data;
    cluster   <= rq.clus;
    do @(posedge clk); while (!in_ready);
    results_due.push_back(due);
    items_sent++;
  endtask

  // Load every byte the request would read that holds no data yet, then
  // send the request itself.
  task automatic offer_loaded(input fat_req_t rq);
    fat_req_t fill;
    fat_rsp_t dry;
    int       unk;
    predict_table_op(rq, 1'b0, dry, unk);
    while (unk >= 0) begin
      fill.mode = MODE_LOAD;
      fill.addr = 13'(unk);
      fill.data = 8'($urandom);
      fill.clus = 12'($urandom);
      offer(fill, 1'b0, '0);
      predict_table_op(rq, 1'b0, dry, unk);
    end
    offer(rq, 1'b0, '0);
  endtask

  // Store link v in entry c as two byte loads, keeping the neighbor's nibble.
  task automatic write_link(input int c, input logic [11:0] v);
    int          off;
    logic [7:0]  lo_byte;
    logic [7:0]  hi_byte;
    fat_req_t    rq;
    off = c + (c >> 1);
    lo_byte = fat_known[off] ? fat_bytes[off] : 8'($urandom);
    hi_byte = fat_known[off + 1] ? fat_bytes[off + 1] : 8'($urandom);
    if (c % 2 == 1) begin
      lo_byte[7:4] = v[3:0];
      hi_byte      = v[11:4];
    end else begin
      lo_byte      = v[7:0];
      hi_byte[3:0] = v[11:8];
    end
    rq.mode = MODE_LOAD;
    rq.clus = 12'($urandom);
    rq.addr = 13'(off);
    rq.data = lo_byte;
    offer(rq, 1'b0, '0);
    rq.addr = 13'(off + 1);
    rq.data = hi_byte;
    offer(rq, 1'b0, '0);
  endtask

  // Write a chain of distinct clusters, look some up, free it from a start
  // near its head, and look back at one member. Half the time the tail is the
  // end mark; otherwise it is a free entry, the reserved link 1, a link past
  // the store, or a link back to the head.
  task automatic build_chain(input bit top_end);
    int          links [$];
    bit          taken [int];
    int          length;
    int          lo;
    int          hi;
    int          c;
    logic [11:0] tail;
    fat_req_t    rq;
    length = $urandom_range(1, 6);
    lo = top_end ? 3040 : 2;
    hi = top_end ? 3071 : 90;
    while (links.size() < length) begin
      c = $urandom_range(lo, hi);
      if (!taken.exists(c)) begin
        taken[c] = 1'b1;
        links.push_back(c);
      end
    end
    case ($urandom_range(0, 7))
      0:       tail = 12'h000;
      1:       tail = 12'h001;
      2:       tail = 12'($urandom_range(3072, 4095));
      3:       tail = 12'(links[0]);
      default: tail = CHAIN_END;
    endcase
    for (int k = 0; k < length; k++) begin
      write_link(links[k], (k == length - 1) ? tail : 12'(links[k + 1]));
    end
    rq.addr = 13'($urandom);
    rq.data = 8'($urandom);
    repeat ($urandom_range(0, 2)) begin
      rq.mode = MODE_LOOKUP;
      rq.clus = 12'(links[$urandom_range(0, length - 1)]);
      offer_loaded(rq);
    end
    rq.mode = MODE_FREE;
    rq.clus = 12'(links[$urandom_range(0, length / 2)]);
    offer_loaded(rq);
    c = links[$urandom_range(0, length - 1)];
    if ($urandom_range(0, 1) == 1) begin
      rq.mode = MODE_LOOKUP;
      rq.clus = 12'(c);
    end else begin
      rq.mode = MODE_READ;
      rq.addr = 13'(c + (c >> 1) + $urandom_range(0, 1));
    end
    offer_loaded(rq);
  endtask

  // Stop offering and wait until every outstanding result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Result side: take each offered result and compare it with the oldest
  // expectation, one field at a time.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_rsp = '{read_byte, next_cluster, freed_count, status};
      if (results_due.size() == 0) begin
        note_failure("result offered with no request outstanding");
      end else begin
        want_rsp = results_due.pop_front();
        if (got_rsp.read_byte !== want_rsp.read_byte ||
            got_rsp.next_cluster !== want_rsp.next_cluster ||
            got_rsp.freed_count !== want_rsp.freed_count ||
            got_rsp.status !== want_rsp.status) begin
          note_failure($sformatf({"mismatch: read_byte %h/%h next_cluster %h/%h ",
                                  "freed_count %0d/%0d status %0d/%0d (expected/actual)"},
                                 want_rsp.read_byte, got_rsp.read_byte,
                                 want_rsp.next_cluster, got_rsp.next_cluster,
                                 want_rsp.freed_count, got_rsp.freed_count,
                                 want_rsp.status, got_rsp.status));
        end
      end
    end
  end

  // Receiver back-pressure. It stalls at random, except in the calm stretch,
  // and on request holds off for a long count of its own so that the block
  // backs up and stops taking requests.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_done != hold_asked) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = hold_asked;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    fat_req_t rq;
    bit       held;
    bit       paused;
    held   = 1'b0;
    paused = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (probe_rows[i]) begin
      offer(probe_rows[i].req, probe_rows[i].typed, probe_rows[i].rsp);
    end

    while (items_sent < PROBE_ROWS + RANDOM_ITEMS) begin
      calm = (items_sent >= 260 && items_sent < 340);
      if (!held && items_sent >= 150) begin
        held = 1'b1;
        hold_asked++;
      end
      if (!paused && items_sent >= 420) begin
        paused = 1'b1;
        drain();
      end
      if ($urandom_range(0, 99) < 60) begin
        build_chain($urandom_range(0, 99) < 15);
      end else begin
        // Noise: half the time the full field range, else near the chains.
        rq.mode = mode_t'($urandom_range(0, 3));
        rq.addr = ($urandom_range(0, 1) == 1) ? 13'($urandom_range(0, 8191))
                                              : 13'($urandom_range(0, 140));
        rq.data = 8'($urandom);
        rq.clus = ($urandom_range(0, 1) == 1) ? 12'($urandom)
                                              : 12'($urandom_range(0, 92));
        offer_loaded(rq);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("fat12_chain_table_tb: PASS");
    end else begin
      $display("fat12_chain_table_tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("fat12_chain_table_tb: FAIL");
    $finish;
  end

endmodule
